// ===== hdl/sem_pkg.sv =====
package sem_pkg;

  // Line store geometry.
  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WEFF_W    = COL_W + 1;

  // Field widths.
  localparam int PIX_W  = 8;
  localparam int ROW_W  = 16;
  localparam int EDGE_W = 8;

  // Configuration registers.
  localparam int CFG_WIDTH_W  = 12;
  localparam int CFG_HEIGHT_W = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_WIDTH_W-1:0]  RESET_WIDTH  = CFG_WIDTH_W'(1024);
  localparam logic [CFG_HEIGHT_W-1:0] RESET_HEIGHT = CFG_HEIGHT_W'(768);

  // Gradient arithmetic: |gx|, |gy| <= 1020.
  localparam int GRAD_W = 11;
  localparam int ABS_W  = GRAD_W - 1;
  localparam int SQ_W   = 2 * ABS_W;
  localparam int SUM_W  = SQ_W + 1;
  localparam int ROOT_W = 8;
  localparam int RIDX_W = $clog2(ROOT_W);
  localparam int RSQ_W  = 2 * ROOT_W;

  // Above this sum the rounded root is at least 256 and saturates.
  localparam logic [SUM_W-1:0]  SAT_LIMIT = SUM_W'(65280);
  localparam logic [EDGE_W-1:0] MAG_MAX   = EDGE_W'(255);

  // Result slots of one job, in emission order.
  localparam int NUM_SLOTS  = 4;
  localparam int SLOT_INNER = 0;
  localparam int SLOT_RIGHT = 1;
  localparam int SLOT_BOT   = 2;
  localparam int SLOT_LAST  = 3;

  // Job queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [NUM_SLOTS-1:0]     slots;
    logic                     interior;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic [COL_W-1:0]         col;
    logic [ROW_W-1:0]         row;
  } sem_job_t;

  typedef enum logic {
    F_ACCEPT,
    F_CALC
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SQUARE,
    B_SUM,
    B_ROOT,
    B_ROUND,
    B_EMIT
  } back_state_t;

endpackage

// ===== hdl/sem_if.sv =====
interface sem_pix_if;
  import sem_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface sem_res_if;
  import sem_pkg::*;

  logic              valid;
  logic              ready;
  logic [EDGE_W-1:0] edge_value;
  logic [COL_W-1:0]  out_x;
  logic [ROW_W-1:0]  out_y;
  logic              last;

  modport source (output valid, output edge_value, output out_x, output out_y,
                  output last, input ready);
  modport sink   (input valid, input edge_value, input out_x, input out_y,
                  input last, output ready);
endinterface

// ===== hdl/sem_ram.sv =====
module sem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/sem_front.sv =====
module sem_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data,
  sem_pix_if.sink                       pixels,
  output logic                          push_valid,
  input  logic                          push_ready,
  output sem_pkg::sem_job_t             push_job
);
  import sem_pkg::*;

  front_state_t state, state_next;

  logic [CFG_WIDTH_W-1:0]  image_width;
  logic [CFG_HEIGHT_W-1:0] image_height;
  logic [WEFF_W-1:0]       w_eff;
  logic [ROW_W-1:0]        h_eff;

  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [PIX_W-1:0] cur_pix;
  logic [PIX_W-1:0] win [6];

  logic             wrap_col;
  logic [ROW_W:0]   row_inc;
  logic [COL_W-1:0] start_col;
  logic [ROW_W-1:0] start_row;
  logic [COL_W-1:0] rd_addr;
  logic [PIX_W-1:0] top_new;
  logic [PIX_W-1:0] mid_new;
  logic             advance;
  logic             has_up;
  logic             has_left;
  logic             at_right;
  logic             at_bottom;
  logic [GRAD_W-1:0] pos_x, neg_x, pos_y, neg_y;
  logic [WEFF_W-1:0] col_inc;
  logic [ROW_W:0]    row_next_inc;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RESET_WIDTH;
      image_height <= RESET_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_width == '0) begin
      w_eff = WEFF_W'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w_eff = WEFF_W'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_W'(image_width);
    end
    h_eff = (image_height == '0) ? ROW_W'(1) : image_height;
  end

  // A size change may leave the position outside the image; fold it back.
  always_comb begin
    wrap_col  = {1'b0, column_count} >= w_eff;
    row_inc   = wrap_col ? ({1'b0, row_count} + (ROW_W+1)'(1)) : {1'b0, row_count};
    start_col = wrap_col ? '0 : column_count;
    start_row = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[ROW_W-1:0];
  end

  assign rd_addr = (state == F_ACCEPT) ? start_col : cur_col;

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
    .clk   (clk),
    .we    (advance),
    .waddr (cur_col),
    .wdata (mid_new),
    .raddr (rd_addr),
    .rdata (top_new)
  );

  sem_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_middle (
    .clk   (clk),
    .we    (advance),
    .waddr (cur_col),
    .wdata (cur_pix),
    .raddr (rd_addr),
    .rdata (mid_new)
  );

  // Classification of the results that this pixel releases.
  always_comb begin
    has_up    = cur_row != '0;
    has_left  = cur_col != '0;
    at_right  = {1'b0, cur_col} == (w_eff - WEFF_W'(1));
    at_bottom = cur_row == (h_eff - ROW_W'(1));

    pos_x = GRAD_W'(top_new) + {(GRAD_W-1)'(mid_new), 1'b0} + GRAD_W'(cur_pix);
    neg_x = GRAD_W'(win[0]) + {(GRAD_W-1)'(win[1]), 1'b0} + GRAD_W'(win[2]);
    pos_y = GRAD_W'(win[0]) + {(GRAD_W-1)'(win[3]), 1'b0} + GRAD_W'(top_new);
    neg_y = GRAD_W'(win[2]) + {(GRAD_W-1)'(win[5]), 1'b0} + GRAD_W'(cur_pix);

    push_job.slots[SLOT_INNER] = has_up && has_left;
    push_job.slots[SLOT_RIGHT] = has_up && at_right;
    push_job.slots[SLOT_BOT]   = at_bottom && has_left;
    push_job.slots[SLOT_LAST]  = at_bottom && at_right;
    push_job.interior = (cur_col >= COL_W'(2)) && (cur_row >= ROW_W'(2));
    push_job.gx       = $signed(pos_x - neg_x);
    push_job.gy       = $signed(pos_y - neg_y);
    push_job.col      = cur_col;
    push_job.row      = cur_row;
  end

  always_comb begin
    state_next    = state;
    pixels.ready  = 1'b0;
    push_valid    = 1'b0;
    advance       = 1'b0;
    unique case (state)
      F_ACCEPT: begin
        pixels.ready = 1'b1;
        if (pixels.valid) begin
          state_next = F_CALC;
        end
      end
      F_CALC: begin
        push_valid = push_job.slots != '0;
        advance    = !push_valid || push_ready;
        if (advance) begin
          state_next = F_ACCEPT;
        end
      end
      default: state_next = F_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    col_inc      = {1'b0, cur_col} + WEFF_W'(1);
    row_next_inc = {1'b0, cur_row} + (ROW_W+1)'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (advance) begin
      if (col_inc >= w_eff) begin
        column_count <= '0;
        row_count    <= (row_next_inc >= {1'b0, h_eff}) ? '0 : row_next_inc[ROW_W-1:0];
      end else begin
        column_count <= col_inc[COL_W-1:0];
        row_count    <= cur_row;
      end
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top_new;
      win[4] <= mid_new;
      win[5] <= cur_pix;
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_ACCEPT && pixels.valid) begin
      cur_col <= start_col;
      cur_row <= start_row;
      cur_pix <= pixels.pixel;
    end
  end

endmodule

// ===== hdl/sem_queue.sv =====
module sem_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  sem_pkg::sem_job_t push_job,
  output logic              pop_valid,
  input  logic              pop_ready,
  output sem_pkg::sem_job_t pop_job
);
  import sem_pkg::*;

  sem_job_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != (QPTR_W+1)'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_job    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== hdl/sem_back.sv =====
module sem_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  sem_pkg::sem_job_t pop_job,
  sem_res_if.source         edges
);
  import sem_pkg::*;

  back_state_t state, state_next;

  sem_job_t              job;
  logic [NUM_SLOTS-1:0]  slots;
  logic [SQ_W-1:0]       sq_x;
  logic [SQ_W-1:0]       sq_y;
  logic [RSQ_W-1:0]      s_low;
  logic [ROOT_W-1:0]     root;
  logic [RIDX_W-1:0]     bit_idx;
  logic [EDGE_W-1:0]     mag;

  logic [ABS_W-1:0]      abs_x, abs_y;
  logic [SUM_W-1:0]      sum;
  logic [ROOT_W-1:0]     trial;
  logic [RSQ_W-1:0]      trial_sq;
  logic [RSQ_W:0]        round_ref;
  logic                  round_up;

  logic                  load;
  logic [NUM_SLOTS-1:0]  slot_clear;
  logic [EDGE_W-1:0]     sel_value;
  logic [COL_W-1:0]      sel_x;
  logic [ROW_W-1:0]      sel_y;
  logic                  sel_last;

  always_comb begin
    abs_x     = job.gx[GRAD_W-1] ? ABS_W'(-job.gx) : ABS_W'(job.gx);
    abs_y     = job.gy[GRAD_W-1] ? ABS_W'(-job.gy) : ABS_W'(job.gy);
    sum       = {1'b0, sq_x} + {1'b0, sq_y};
    trial     = root | (ROOT_W'(1) << bit_idx);
    trial_sq  = RSQ_W'(trial) * RSQ_W'(trial);
    round_ref = {1'b0, RSQ_W'(root) * RSQ_W'(root)} + (RSQ_W+1)'(root);
    round_up  = {1'b0, s_low} > round_ref;
  end

  // Lowest pending slot goes out first.
  always_comb begin
    slot_clear = '0;
    sel_value  = '0;
    sel_x      = job.col - COL_W'(1);
    sel_y      = job.row - ROW_W'(1);
    sel_last   = 1'b0;
    if (slots[SLOT_INNER]) begin
      slot_clear[SLOT_INNER] = 1'b1;
      sel_value = job.interior ? mag : '0;
    end else if (slots[SLOT_RIGHT]) begin
      slot_clear[SLOT_RIGHT] = 1'b1;
      sel_x = job.col;
    end else if (slots[SLOT_BOT]) begin
      slot_clear[SLOT_BOT] = 1'b1;
      sel_y = job.row;
    end else begin
      slot_clear[SLOT_LAST] = 1'b1;
      sel_x    = job.col;
      sel_y    = job.row;
      sel_last = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    pop_ready  = 1'b0;
    load       = 1'b0;
    unique case (state)
      B_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          state_next = pop_job.interior ? B_SQUARE : B_EMIT;
        end
      end
      B_SQUARE: state_next = B_SUM;
      B_SUM:    state_next = (sum > SAT_LIMIT) ? B_EMIT : B_ROOT;
      B_ROOT: begin
        if (bit_idx == '0) begin
          state_next = B_ROUND;
        end
      end
      B_ROUND: state_next = B_EMIT;
      B_EMIT: begin
        if (slots == '0) begin
          state_next = B_IDLE;
        end else if (!edges.valid || edges.ready) begin
          load = 1'b1;
          if ((slots & ~slot_clear) == '0) begin
            state_next = B_IDLE;
          end
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= B_IDLE;
      slots       <= '0;
      edges.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == B_IDLE && pop_valid) begin
        slots <= pop_job.slots;
      end else if (load) begin
        slots <= slots & ~slot_clear;
      end
      if (load) begin
        edges.valid <= 1'b1;
      end else if (edges.ready) begin
        edges.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_IDLE && pop_valid) begin
      job <= pop_job;
    end
    unique case (state)
      B_SQUARE: begin
        sq_x <= SQ_W'(abs_x) * SQ_W'(abs_x);
        sq_y <= SQ_W'(abs_y) * SQ_W'(abs_y);
      end
      B_SUM: begin
        s_low   <= sum[RSQ_W-1:0];
        root    <= '0;
        bit_idx <= RIDX_W'(ROOT_W - 1);
        mag     <= MAG_MAX;
      end
      B_ROOT: begin
        if (trial_sq <= s_low) begin
          root <= trial;
        end
        bit_idx <= bit_idx - RIDX_W'(1);
      end
      B_ROUND: begin
        if (round_up) begin
          mag <= (root == MAG_MAX) ? MAG_MAX : EDGE_W'(root + ROOT_W'(1));
        end else begin
          mag <= EDGE_W'(root);
        end
      end
      default: ;
    endcase
    if (load) begin
      edges.edge_value <= sel_value;
      edges.out_x      <= sel_x;
      edges.out_y      <= sel_y;
      edges.last       <= sel_last;
    end
  end

endmodule

// ===== hdl/sobel_edge_magnitude_core.sv =====
// Channel   Role    Word
// -------   -----   ------------------------------------------------------
// pixels    sink    pixel: 8-bit grey sample, raster order
// edges     source  edge_value, out_x, out_y, last: one result per word
// cfg       write   cfg_we, cfg_index (0 width, 1 height), cfg_data
//
// The front reads the two line stores as it takes a pixel word, then forms
// the gradients and writes the stores back before taking the next. The back
// picks up a job, does the magnitude work of an interior pixel (squares, sum,
// an 8-step square root, rounding; root and rounding are skipped when the
// sum saturates), then sends one word per cycle unless the edges sink stalls.
// A 4-deep job queue lets the front run ahead while the back or the edges
// sink stalls. Reset is synchronous; line store contents are not cleared.
module sobel_edge_magnitude_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data,
  sem_pix_if.sink                       pixels,
  sem_res_if.source                     edges
);
  import sem_pkg::*;

  // Jobs from the front to the back. Each job holds the gradients of one
  // pixel window plus a mask of up to four result words that the pixel
  // releases: the interior result one row up and to the left, the right
  // border of the row above, and on the bottom row its own border words.
  logic     push_valid;
  logic     push_ready;
  sem_job_t push_job;
  logic     pop_valid;
  logic     pop_ready;
  sem_job_t pop_job;

  // The front owns the size registers, position counters, line stores
  // and the 3x3 window. Jobs with no result words are never queued.
  sem_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pixels     (pixels),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  // The queue decouples classification from the magnitude unit.
  sem_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // The back computes the rounded, saturated magnitude and sends the
  // result words in order through a registered output stage.
  sem_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .edges     (edges)
  );

endmodule

// ===== tb/sobel_edge_magnitude_core_tb.sv =====
module sobel_edge_magnitude_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sem_pkg::*;

  // A pixel job can still be inside the core after the last edge word has
  // left. The job queue is 4 deep and each job needs the magnitude work plus
  // up to 4 result words, and this settle time covers that.
  localparam int SETTLE_CYCLES  = 100;
  // The edges sink holds off this long once, so that the job queue fills
  // and the core stops taking pixels.
  localparam int LONG_HOLD      = 300;
  // Cycles without any accepted word before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 5000;
  // A plan row whose expected words come from the predictor.
  localparam int PREDICTED      = -1;

  // Random images: a few have a fixed role.
  localparam int NUM_IMAGES  = 19;
  localparam int TALL_IMAGE  = 1;
  localparam int WIDE_IMAGE  = 4;
  localparam int HOLD_IMAGE  = 6;
  localparam int PAUSE_IMAGE = 9;

  typedef struct packed {
    logic [EDGE_W-1:0] edge_value;
    logic [COL_W-1:0]  x;
    logic [ROW_W-1:0]  y;
    logic              last;
  } edge_word_t;

  typedef enum {ROW_CFG, ROW_PIXEL} plan_kind_t;

  typedef struct {
    plan_kind_t            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [PIX_W-1:0]      px;
    int                    n_typed;
  } plan_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sem_pix_if pixel_bus ();
  sem_res_if edge_bus ();

  sobel_edge_magnitude_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pixel_bus),
    .edges     (edge_bus)
  );

  always #5 clk = ~clk;

  // Expected edge words in emission order, and the words one pixel causes.
  edge_word_t pending_edges[$];
  edge_word_t step_words[$];

  // Directed stimulus table and the hand-written words some rows expect.
  plan_row_t  plan[$];
  edge_word_t typed_words[$];

  int fail_count     = 0;
  int sender_gap_pct = 25;
  int quiet_cycles   = 0;
  bit tail_quiet     = 1'b0;
  bit hold_request   = 1'b0;

  // Predictor state: raw register values, the two line stores, the window
  // of the two previous columns and the position of the next pixel.
  logic [CFG_WIDTH_W-1:0]  width_reg  = RESET_WIDTH;
  logic [CFG_HEIGHT_W-1:0] height_reg = RESET_HEIGHT;
  logic [PIX_W-1:0]        upper_row  [MAX_WIDTH];
  logic [PIX_W-1:0]        middle_row [MAX_WIDTH];
  logic [PIX_W-1:0]        win        [6];
  int unsigned             col_next   = 0;
  int unsigned             row_next   = 0;

  function automatic edge_word_t make_word(input int v, input int x, input int y,
                                           input int l);
    edge_word_t w;
    w.edge_value = EDGE_W'(v);
    w.x          = COL_W'(x);
    w.y          = ROW_W'(y);
    w.last       = l[0];
    return w;
  endfunction

  // Rounded integer square root of gx^2 + gy^2, saturated to 255. The root
  // is built bit by bit; rounding up happens when s lies above n^2 + n.
  function automatic logic [EDGE_W-1:0] sobel_magnitude(input int gx, input int gy);
    int unsigned sq;
    int unsigned root;
    int unsigned trial;
    int          b;
    sq = gx * gx + gy * gy;
    if (sq > 65280) return MAG_MAX;
    root = 0;
    for (b = 8; b >= 0; b--) begin
      trial = root | (1 << b);
      if (trial * trial <= sq) root = trial;
    end
    if (sq > root * root + root) root++;
    if (root > 255) root = 255;
    return EDGE_W'(root);
  endfunction

  // Advances the predictor by one pixel and leaves its edge words in
  // step_words: the result one row up and one column left, the right border
  // word at the end of a row, and on the bottom row its own border words.
  function automatic void predict_pixel(input logic [PIX_W-1:0] px);
    int unsigned      w, h, c, r;
    int               tl, ml, bl, tc, bc, tr, mr, br, gx, gy;
    logic [PIX_W-1:0] top_new, mid_new;
    logic [EDGE_W-1:0] mag;
    step_words.delete();
    w = (width_reg == 0) ? 1 : width_reg;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = (height_reg == 0) ? 1 : height_reg;
    // A size write may have left the position outside the new image.
    if (col_next >= w) begin
      col_next = 0;
      row_next++;
    end
    if (row_next >= h) row_next = 0;
    c = col_next;
    r = row_next;
    top_new = upper_row[c];
    mid_new = middle_row[c];
    if (r >= 1) begin
      if (c >= 1) begin
        mag = '0;
        if (c >= 2 && r >= 2) begin
          tl = win[0];
          ml = win[1];
          bl = win[2];
          tc = win[3];
          bc = win[5];
          tr = top_new;
          mr = mid_new;
          br = px;
          gx = -tl + tr - 2 * ml + 2 * mr - bl + br;
          gy = tl + 2 * tc + tr - bl - 2 * bc - br;
          mag = sobel_magnitude(gx, gy);
        end
        step_words.push_back(make_word(mag, c - 1, r - 1, 0));
      end
      if (c == w - 1) step_words.push_back(make_word(0, w - 1, r - 1, 0));
    end
    if (r == h - 1) begin
      if (c >= 1) step_words.push_back(make_word(0, c - 1, r, 0));
      if (c == w - 1) step_words.push_back(make_word(0, w - 1, r, 1));
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = top_new;
    win[4] = mid_new;
    win[5] = px;
    upper_row[c]  = mid_new;
    middle_row[c] = px;
    col_next = c + 1;
    if (col_next >= w) begin
      col_next = 0;
      row_next = r + 1;
      if (row_next >= h) row_next = 0;
    end
  endfunction

  function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row.kind    = ROW_CFG;
    row.idx     = idx;
    row.data    = data;
    row.px      = '0;
    row.n_typed = 0;
    plan.push_back(row);
  endfunction

  function automatic void add_pixel(input int px, input int n_typed);
    plan_row_t row;
    row.kind    = ROW_PIXEL;
    row.idx     = '0;
    row.data    = '0;
    row.px      = PIX_W'(px);
    row.n_typed = n_typed;
    plan.push_back(row);
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one pixel word, waits for the handshake and then files the edge
  // words it causes, either hand-written ones or predicted ones.
  task automatic send_pixel(input logic [PIX_W-1:0] px, input int n_typed);
    if (!tail_quiet && $urandom_range(0, 99) < sender_gap_pct) begin
      pixel_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    pixel_bus.valid <= 1'b1;
    pixel_bus.pixel <= px;
    do @(posedge clk); while (!pixel_bus.ready);
    predict_pixel(px);
    if (n_typed == PREDICTED) begin
      foreach (step_words[i]) pending_edges.push_back(step_words[i]);
    end else begin
      repeat (n_typed) pending_edges.push_back(typed_words.pop_front());
    end
  endtask

  task automatic wait_drained();
    pixel_bus.valid <= 1'b0;
    do @(posedge clk); while (pending_edges.size() != 0);
  endtask

  // Registers change only while the core is idle: every expected word has
  // left, and any job that causes no word has had time to finish.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = data[CFG_WIDTH_W-1:0];
    else height_reg = data[CFG_HEIGHT_W-1:0];
  endtask

  // Edges sink. Every 50 steps it picks how often to stall (never, seldom or
  // often). One long hold is taken on request.
  initial begin : edge_sink
    int stall_pct;
    int span;
    stall_pct = 0;
    span      = 0;
    edge_bus.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (span <= 0) begin
        span = 50;
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 35;
        endcase
      end
      span--;
      if (hold_request) begin
        edge_bus.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else if (!tail_quiet && $urandom_range(0, 99) < stall_pct) begin
        edge_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        edge_bus.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Each accepted edge word is compared with the oldest expectation.
  always @(posedge clk) begin : edge_check
    edge_word_t want;
    if (!rst && edge_bus.valid && edge_bus.ready) begin
      if (pending_edges.size() == 0) begin
        $error("unexpected edge word: edge_value %0d at (%0d,%0d) last %0d",
               edge_bus.edge_value, edge_bus.out_x, edge_bus.out_y, edge_bus.last);
        fail_count++;
      end else begin
        want = pending_edges.pop_front();
        if (edge_bus.edge_value !== want.edge_value) begin
          $error("edge_value at (%0d,%0d): expected %0d, actual %0d",
                 want.x, want.y, want.edge_value, edge_bus.edge_value);
          fail_count++;
        end
        if (edge_bus.out_x !== want.x) begin
          $error("out_x: expected %0d, actual %0d", want.x, edge_bus.out_x);
          fail_count++;
        end
        if (edge_bus.out_y !== want.y) begin
          $error("out_y: expected %0d, actual %0d", want.y, edge_bus.out_y);
          fail_count++;
        end
        if (edge_bus.last !== want.last) begin
          $error("last at (%0d,%0d): expected %0d, actual %0d",
                 want.x, want.y, want.last, edge_bus.last);
          fail_count++;
        end
      end
    end
  end

  // A run that stops moving words on both channels is hung.
  always @(posedge clk) begin
    if (rst || (pixel_bus.valid && pixel_bus.ready) || (edge_bus.valid && edge_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("sobel_edge_magnitude_core_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int img, w, h, cut;
    pixel_bus.valid <= 1'b0;
    pixel_bus.pixel <= '0;
    foreach (win[i]) win[i] = '0;

    // Directed part. Right after reset the width is still 1024; with a
    // height of 1 every pixel but the first gives a bottom border word.
    add_cfg(REG_IMAGE_HEIGHT, CFG_DATA_W'(1));
    add_pixel(0, 0);
    add_pixel(255, 1);
    typed_words.push_back(make_word(0, 0, 0, 0));
    // Shrinking the width under the current column wraps to the next row,
    // which lies past the height, so the next pixel starts a new image.
    add_cfg(REG_IMAGE_WIDTH, CFG_DATA_W'(2));
    add_pixel(8'h5a, 0);
    add_pixel(8'ha5, 2);
    typed_words.push_back(make_word(0, 0, 0, 0));
    typed_words.push_back(make_word(0, 1, 0, 1));
    // Zero sizes act as 1x1: every pixel is a whole image of one border word.
    add_cfg(REG_IMAGE_WIDTH, CFG_DATA_W'(0));
    add_cfg(REG_IMAGE_HEIGHT, CFG_DATA_W'(0));
    add_pixel(0, 1);
    typed_words.push_back(make_word(0, 0, 0, 1));
    add_pixel(255, 1);
    typed_words.push_back(make_word(0, 0, 0, 1));
    // 3x3 with only the right column at full scale: gx is the largest
    // possible, gy is zero, and the single interior word saturates.
    add_cfg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
    add_cfg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
    add_pixel(0, 0);
    add_pixel(0, 0);
    add_pixel(255, 0);
    add_pixel(0, 0);
    add_pixel(0, 1);
    typed_words.push_back(make_word(0, 0, 0, 0));
    add_pixel(255, 2);
    typed_words.push_back(make_word(0, 1, 0, 0));
    typed_words.push_back(make_word(0, 2, 0, 0));
    add_pixel(0, 0);
    add_pixel(0, 2);
    typed_words.push_back(make_word(0, 0, 1, 0));
    typed_words.push_back(make_word(0, 0, 2, 0));
    add_pixel(255, 4);
    typed_words.push_back(make_word(255, 1, 1, 0));
    typed_words.push_back(make_word(0, 2, 1, 0));
    typed_words.push_back(make_word(0, 1, 2, 0));
    typed_words.push_back(make_word(0, 2, 2, 1));
    // Same size with a bright top row: the vertical gradient saturates.
    for (int i = 0; i < 9; i++) add_pixel((i < 3) ? 255 : 0, PREDICTED);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) write_reg(plan[i].idx, plan[i].data);
      else send_pixel(plan[i].px, plan[i].n_typed);
    end

    // Random part: whole images of random content, mostly small. One starts
    // with a width register above the line store size and is narrowed after
    // a few pixels, one starts with the tallest height, and some are cut
    // short by a size write in mid-image.
    for (img = 0; img < NUM_IMAGES; img++) begin
      tail_quiet     = (img >= NUM_IMAGES - 3);
      sender_gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
      if (img == WIDE_IMAGE) begin
        w = 4095;
        h = 3;
      end else if (img == TALL_IMAGE) begin
        w = $urandom_range(3, 6);
        h = 65535;
      end else if (img == HOLD_IMAGE || img == PAUSE_IMAGE) begin
        w = 10;
        h = 5;
      end else begin
        w = $urandom_range(1, 10);
        h = $urandom_range(1, 5);
      end
      write_reg(REG_IMAGE_WIDTH, {4'($urandom_range(0, 15)), 12'(w)});
      write_reg(REG_IMAGE_HEIGHT, 16'(h));
      if (img == HOLD_IMAGE) hold_request = 1'b1;

      cut = 0;
      if (img == TALL_IMAGE) cut = 3 * w + $urandom_range(0, w - 1);
      else if (img == PAUSE_IMAGE) cut = $urandom_range(15, 35);
      else if (img == WIDE_IMAGE) cut = $urandom_range(10, 30);
      else if (w * h >= 4 && $urandom_range(0, 4) == 0)
        cut = $urandom_range(1, w * h - 1);
      if (cut != 0) begin
        repeat (cut) send_pixel(pick_pixel(), PREDICTED);
        if (img == PAUSE_IMAGE) begin
          // The sender rests until every expected word has come out.
          wait_drained();
        end else if (img == TALL_IMAGE) begin
          write_reg(REG_IMAGE_HEIGHT, 16'($urandom_range(1, 3)));
        end else if (img == WIDE_IMAGE) begin
          // Narrowing below the current column wraps to the next row.
          write_reg(REG_IMAGE_WIDTH, 16'($urandom_range(3, 8)));
        end else if ($urandom_range(0, 1) == 0) begin
          write_reg(REG_IMAGE_HEIGHT, 16'($urandom_range(1, h)));
        end else begin
          write_reg(REG_IMAGE_WIDTH,
                    {4'($urandom_range(0, 15)), 12'($urandom_range(1, w))});
        end
      end
      // Finish the image, whatever size it has now.
      do send_pixel(pick_pixel(), PREDICTED); while (col_next != 0 || row_next != 0);
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("sobel_edge_magnitude_core_tb: PASS");
    end else begin
      $display("sobel_edge_magnitude_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/sem_pkg.sv
hdl/sem_if.sv
hdl/sem_ram.sv
hdl/sem_front.sv
hdl/sem_queue.sv
hdl/sem_back.sv
hdl/sobel_edge_magnitude_core.sv
tb/sobel_edge_magnitude_core_tb.sv
